// File: hdl/rwc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared constants and types of the RGB window convolution unit.
// ----------------------------------------------------------------------------
package rwc_pkg;

  localparam int RWC_MAX_WIDTH  = 1024;
  localparam int RWC_MAX_WINDOW = 5;
  localparam int RWC_COEF_BITS  = 8;

  localparam int          PADDR_W        = 6;
  localparam int          PDATA_W        = 64;
  localparam logic [10:0] FRAME_W_RESET  = 11'd1024;
  localparam logic [15:0] FRAME_H_RESET  = 16'd768;
  localparam logic [7:0]  PIX_MAX        = 8'd255;

  typedef enum logic [2:0] {
    REG_WINDOW_FIVE  = 3'd0,
    REG_COEF_A       = 3'd1,
    REG_COEF_B       = 3'd2,
    REG_COEF_C       = 3'd3,
    REG_COEF_D       = 3'd4,
    REG_DIVISOR      = 3'd5,
    REG_FRAME_WIDTH  = 3'd6,
    REG_FRAME_HEIGHT = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT,
    S_DECIDE,
    S_BREAD,
    S_BDATA,
    S_MAC,
    S_DRAIN,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT
  } state_e;

endpackage
`default_nettype wire

// File: hdl/rwc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwc_in_if
// Pixel request channel into the convolution unit.
// ----------------------------------------------------------------------------
interface rwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       pad;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, pad, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, pad, output ready);
endinterface
`default_nettype wire

// File: hdl/rwc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwc_out_if
// Filtered pixel request channel out of the convolution unit.
// ----------------------------------------------------------------------------
interface rwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface
`default_nettype wire

// File: hdl/rwc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 6144
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: hdl/rwc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwc_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output      logic             done_o,
  output      logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W-1:0] diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted[DEN_W-1:0] - den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff : shifted[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

// File: hdl/rgb_window_convolution_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_window_convolution_unit
// Streaming 3x3/5x5 RGB convolution over a line store held in one RAM.
// ----------------------------------------------------------------------------
// A request with no result returns to idle; a border pixel is read from the line
//   store; an interior pixel is a MAC over the line store RAM (one read port, one
//   tap per cycle), followed by the shared divider, one channel after another,
//   when the divisor is nonzero. One request in flight at a time.
// The result register lets the next request enter while a result waits.
// Reset: state, counters and settings to defaults; the line store is not cleared.
module rgb_window_convolution_unit import rwc_pkg::*; #(
  parameter int MAX_WIDTH  = RWC_MAX_WIDTH,
  parameter int MAX_WINDOW = RWC_MAX_WINDOW,
  parameter int COEF_BITS  = RWC_COEF_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  rwc_in_if.sink                  in_if,
  rwc_out_if.source               out_if,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RING  = MAX_WINDOW + 1;
  localparam int RB    = $clog2(RING);
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CB    = (COEF_BITS > 8) ? 8 : COEF_BITS;
  localparam int PW    = CB + 9;
  localparam int SW    = PW + 5;
  localparam int NW    = 16 + WW + 1;
  localparam bit HAS_FIVE = (MAX_WINDOW >= 5);

  // configuration registers
  logic        win5_q;
  logic [63:0] coef_a_q, coef_b_q, coef_c_q;
  logic [7:0]  coef_d_q;
  logic [15:0] div_q;
  logic [10:0] fw_q;
  logic [15:0] fh_q;
  logic        wr_en;
  reg_idx_e    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win5_q   <= 1'b0;
      coef_a_q <= '0;
      coef_b_q <= '0;
      coef_c_q <= '0;
      coef_d_q <= '0;
      div_q    <= '0;
      fw_q     <= FRAME_W_RESET;
      fh_q     <= FRAME_H_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW_FIVE:  win5_q   <= pwdata[0];
        REG_COEF_A:       coef_a_q <= pwdata;
        REG_COEF_B:       coef_b_q <= pwdata;
        REG_COEF_C:       coef_c_q <= pwdata;
        REG_COEF_D:       coef_d_q <= pwdata[7:0];
        REG_DIVISOR:      div_q    <= pwdata[15:0];
        REG_FRAME_WIDTH:  fw_q     <= pwdata[10:0];
        REG_FRAME_HEIGHT: fh_q     <= pwdata[15:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_FIVE:  prdata = 64'(win5_q);
      REG_COEF_A:       prdata = coef_a_q;
      REG_COEF_B:       prdata = coef_b_q;
      REG_COEF_C:       prdata = coef_c_q;
      REG_COEF_D:       prdata = 64'(coef_d_q);
      REG_DIVISOR:      prdata = 64'(div_q);
      REG_FRAME_WIDTH:  prdata = 64'(fw_q);
      REG_FRAME_HEIGHT: prdata = 64'(fh_q);
      default:          prdata = '0;
    endcase
  end

  // effective geometry
  logic [12:0] fw_ext;
  logic [WW-1:0] w_eff;
  logic [15:0] h_eff;
  logic        two;
  logic [1:0]  rad;
  logic [2:0]  size;

  assign fw_ext = 13'(fw_q);
  assign w_eff  = (fw_ext == '0) ? WW'(1) :
                  (fw_ext > 13'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_ext);
  assign h_eff  = (fh_q == '0) ? 16'd1 : fh_q;
  assign two    = win5_q && HAS_FIVE;
  assign rad    = two ? 2'd2 : 2'd1;
  assign size   = two ? 3'd5 : 3'd3;

  logic signed [CB-1:0] coef_arr [25];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      coef_arr[i]      = coef_a_q[8*i +: CB];
      coef_arr[i + 8]  = coef_b_q[8*i +: CB];
      coef_arr[i + 16] = coef_c_q[8*i +: CB];
    end
    coef_arr[24] = coef_d_q[CB-1:0];
  end

  // counters
  logic [CW-1:0] in_col_q, out_col_q;
  logic [15:0]   in_row_q, out_row_q;
  logic [RB-1:0] in_rowm_q, out_rowm_q;
  logic          complete;
  logic          in_acc, store;
  logic          in_col_wrap, out_col_wrap, last;

  state_e state_q, state_d;

  function automatic logic [RB-1:0] row_inc(input logic [RB-1:0] r);
    row_inc = (r == RB'(RING - 1)) ? '0 : r + RB'(1);
  endfunction

  assign complete     = in_row_q >= h_eff;
  assign in_acc       = in_if.valid && in_if.ready;
  assign store        = in_acc && !complete && !in_if.pad;
  assign in_col_wrap  = (WW'(in_col_q) + WW'(1)) >= w_eff;
  assign out_col_wrap = (WW'(out_col_q) + WW'(1)) >= w_eff;
  assign last         = (17'(out_row_q) + 17'd1 >= 17'(h_eff)) && out_col_wrap;

  // decision terms
  logic [NW-1:0] in_cnt_q, out_cnt_q;
  logic [NW-1:0] need_cnt;
  logic          row_done, short, border;

  assign need_cnt = out_cnt_q + (two ? (NW'(w_eff) << 1) + NW'(3) : NW'(w_eff) + NW'(2));
  assign row_done = out_row_q >= h_eff;
  assign short    = !complete && (in_cnt_q < need_cnt);
  assign border   = (WW'(out_col_q) < WW'(rad)) || (out_row_q < 16'(rad)) ||
                    ((WW + 1)'(out_col_q) + (WW + 1)'(rad) >= (WW + 1)'(w_eff)) ||
                    (17'(out_row_q) + 17'(rad) >= 17'(h_eff));

  // MAC loop state
  logic [CW-1:0] x_q, col_q;
  logic [RB-1:0] ymod_q, rowm_q, rowm_start_q;
  logic          last_q;
  logic [2:0]    tap_k_q, tap_l_q;
  logic [4:0]    tap_idx_q;
  logic          tap_last;
  logic [RB:0]   rs_tmp;
  logic [RB-1:0] rs_start;
  logic          rd_v_q, pv_q;
  logic signed [CB-1:0] coef_q;
  logic signed [PW-1:0] prod_q [3];
  logic signed [SW-1:0] acc_q [3];
  logic [1:0]    ch_q;
  logic [7:0]    res_q [3];

  assign tap_last = (tap_k_q == size - 3'd1) && (tap_l_q == size - 3'd1);
  assign rs_tmp   = (RB + 1)'(out_rowm_q) + (RB + 1)'(RING) - (RB + 1)'(rad);
  assign rs_start = (rs_tmp >= (RB + 1)'(RING)) ? RB'(rs_tmp - (RB + 1)'(RING)) : RB'(rs_tmp);

  // RAM
  logic          ram_re;
  logic [AW-1:0] ram_raddr, ram_waddr;
  logic [23:0]   ram_rdata;

  assign ram_waddr = AW'(in_rowm_q) * AW'(MAX_WIDTH) + AW'(in_col_q);

  rwc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_line_store (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (ram_waddr),
    .wdata_i ({in_if.pixel_red, in_if.pixel_green, in_if.pixel_blue}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // divider
  logic          div_start, div_done;
  logic [SW-1:0] div_num, div_quot;
  logic [15:0]   div_den;
  logic          div_neg, acc_neg;
  logic signed [SW-1:0] acc_sel;

  assign div_neg = div_q[15];
  assign div_den = div_neg ? 16'(-div_q) : div_q;
  assign acc_sel = acc_q[ch_q];
  assign acc_neg = acc_sel[SW-1];
  assign div_num = acc_neg ? SW'(-acc_sel) : SW'(acc_sel);

  rwc_div #(.NUM_W(SW), .DEN_W(16)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  function automatic logic [7:0] clamp_sum(input logic signed [SW-1:0] v);
    if (v < 0) begin
      clamp_sum = 8'd0;
    end else if (v > SW'(PIX_MAX)) begin
      clamp_sum = PIX_MAX;
    end else begin
      clamp_sum = v[7:0];
    end
  endfunction

  // output register
  logic       out_valid_q, out_free;
  logic [7:0] o_red_q, o_green_q, o_blue_q;
  logic       o_end_q;

  assign out_free         = !out_valid_q || out_if.ready;
  assign out_if.valid     = out_valid_q;
  assign out_if.out_red   = o_red_q;
  assign out_if.out_green = o_green_q;
  assign out_if.out_blue  = o_blue_q;
  assign out_if.frame_end = o_end_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_acc) state_d = S_COUNT;
      S_COUNT:     state_d = S_DECIDE;
      S_DECIDE: begin
        if (row_done || short) begin
          state_d = S_IDLE;
        end else if (border) begin
          state_d = S_BREAD;
        end else begin
          state_d = S_MAC;
        end
      end
      S_BREAD:     state_d = S_BDATA;
      S_BDATA:     state_d = S_EMIT;
      S_MAC:       if (tap_last) state_d = S_DRAIN;
      S_DRAIN: begin
        if (!rd_v_q && !pv_q) begin
          state_d = (div_q == '0) ? S_EMIT : S_DIV_START;
        end
      end
      S_DIV_START: state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_d = (ch_q == 2'd2) ? S_EMIT : S_DIV_START;
        end
      end
      S_EMIT:      if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_if.ready = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = AW'(ymod_q) * AW'(MAX_WIDTH) + AW'(x_q);
    div_start   = 1'b0;
    unique case (state_q)
      S_IDLE:      in_if.ready = 1'b1;
      S_BREAD:     ram_re = 1'b1;
      S_MAC: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(rowm_q) * AW'(MAX_WIDTH) + AW'(col_q);
      end
      S_DIV_START: div_start = 1'b1;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_rowm_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_rowm_q  <= '0;
      rd_v_q      <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == S_MAC);
      pv_q    <= rd_v_q;
      if (store) begin
        if (in_col_wrap) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + 16'd1;
          in_rowm_q <= row_inc(in_rowm_q);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (state_q == S_DECIDE) begin
        if (row_done) begin
          if (complete) begin
            in_col_q   <= '0;
            in_row_q   <= '0;
            in_rowm_q  <= '0;
            out_col_q  <= '0;
            out_row_q  <= '0;
            out_rowm_q <= '0;
          end
        end else if (!short) begin
          if (last) begin
            in_col_q   <= '0;
            in_row_q   <= '0;
            in_rowm_q  <= '0;
            out_col_q  <= '0;
            out_row_q  <= '0;
            out_rowm_q <= '0;
          end else if (out_col_wrap) begin
            out_col_q  <= '0;
            out_row_q  <= out_row_q + 16'd1;
            out_rowm_q <= row_inc(out_rowm_q);
          end else begin
            out_col_q <= out_col_q + CW'(1);
          end
        end
      end
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    in_cnt_q  <= NW'(in_row_q) * NW'(w_eff) + NW'(in_col_q);
    out_cnt_q <= NW'(out_row_q) * NW'(w_eff) + NW'(out_col_q);
    coef_q    <= coef_arr[tap_idx_q];
    for (int c = 0; c < 3; c++) begin
      prod_q[c] <= coef_q * $signed({1'b0, ram_rdata[8*(2-c) +: 8]});
      if (pv_q) begin
        acc_q[c] <= acc_q[c] + SW'(prod_q[c]);
      end
    end
    unique case (state_q)
      S_DECIDE: begin
        x_q          <= out_col_q;
        ymod_q       <= out_rowm_q;
        last_q       <= last;
        col_q        <= out_col_q - CW'(rad);
        rowm_q       <= rs_start;
        rowm_start_q <= rs_start;
        tap_k_q      <= '0;
        tap_l_q      <= '0;
        tap_idx_q    <= '0;
        ch_q         <= '0;
        for (int c = 0; c < 3; c++) begin
          acc_q[c] <= '0;
        end
      end
      S_MAC: begin
        tap_idx_q <= tap_idx_q + 5'd1;
        if (tap_l_q == size - 3'd1) begin
          tap_l_q <= '0;
          tap_k_q <= tap_k_q + 3'd1;
          col_q   <= col_q + CW'(1);
          rowm_q  <= rowm_start_q;
        end else begin
          tap_l_q <= tap_l_q + 3'd1;
          rowm_q  <= row_inc(rowm_q);
        end
      end
      S_BDATA: begin
        res_q[0] <= ram_rdata[23:16];
        res_q[1] <= ram_rdata[15:8];
        res_q[2] <= ram_rdata[7:0];
      end
      S_DRAIN: begin
        if (!rd_v_q && !pv_q && div_q == '0) begin
          for (int c = 0; c < 3; c++) begin
            res_q[c] <= clamp_sum(acc_q[c]);
          end
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (acc_neg != div_neg) begin
            res_q[ch_q] <= 8'd0;
          end else if (div_quot > SW'(PIX_MAX)) begin
            res_q[ch_q] <= PIX_MAX;
          end else begin
            res_q[ch_q] <= div_quot[7:0];
          end
          ch_q <= ch_q + 2'd1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          o_red_q   <= res_q[0];
          o_green_q <= res_q[1];
          o_blue_q  <= res_q[2];
          o_end_q   <= last_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB window convolution unit: frames of random
// geometry, window size, coefficients and divisor are streamed with pads and
// dropped pixels, and every filtered pixel is compared with a local predictor.
// ----------------------------------------------------------------------------
module tb;
  import rwc_pkg::*;

  localparam int RING = RWC_MAX_WINDOW + 1;
  localparam int SETTLE = 300;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pad;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } filtered_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  rwc_in_if  in_if();
  rwc_out_if out_if();

  rgb_window_convolution_unit u_dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow configuration and stream state
  logic        win_five;
  logic [63:0] coef_a, coef_b, coef_c;
  logic [7:0]  coef_d;
  logic [15:0] divisor;
  logic [10:0] frame_w;
  logic [15:0] frame_h;
  logic [23:0] line_mem [RING*RWC_MAX_WIDTH];
  int unsigned in_col, in_row, out_col, out_row;

  pixel_t    pending_px[$];
  filtered_t expected_px[$];
  int        errors = 0;
  int        cycles = 0;
  bit        calm = 1'b0;
  bit        took = 1'b0;
  int        send_gap = 0, recv_gap = 0;
  int        hold_off = 0;

  function automatic int unsigned eff_w(logic [10:0] w);
    if (w == 0) return 1;
    if (w > RWC_MAX_WIDTH) return RWC_MAX_WIDTH;
    return 32'(w);
  endfunction

  function automatic int unsigned eff_h(logic [15:0] h);
    return (h == 0) ? 1 : 32'(h);
  endfunction

  function automatic int coef_val(int unsigned i);
    logic [7:0] b;
    if (i < 8) b = coef_a[8*i +: 8];
    else if (i < 16) b = coef_b[8*(i-8) +: 8];
    else if (i < 24) b = coef_c[8*(i-16) +: 8];
    else b = coef_d;
    return int'($signed(b));
  endfunction

  function automatic logic [23:0] fetch(int unsigned x, int unsigned y);
    if (x >= RWC_MAX_WIDTH) return '0;
    return line_mem[(y % RING) * RWC_MAX_WIDTH + x];
  endfunction

  function automatic logic [7:0] clamp(int v);
    if (v < 0) return 8'd0;
    if (v > PIX_MAX) return PIX_MAX;
    return v[7:0];
  endfunction

  task automatic clear_counters();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  task automatic predict_filter(pixel_t it);
    int unsigned w, h, r, sz, x, y, k, l, c;
    longint unsigned inc, outc, dly;
    bit done;
    int sr, sg, sb, cf, dv;
    logic [23:0] p;
    filtered_t e;
    w = eff_w(frame_w);
    h = eff_h(frame_h);
    r = win_five ? 2 : 1;
    sz = 2 * r + 1;
    if (in_row < h && !it.pad) begin
      c = (in_col < RWC_MAX_WIDTH) ? in_col : RWC_MAX_WIDTH - 1;
      line_mem[(in_row % RING) * RWC_MAX_WIDTH + c] = {it.red, it.green, it.blue};
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col++;
      end
    end
    done = in_row >= h;
    if (out_row >= h) begin
      if (done) clear_counters();
      return;
    end
    inc = longint'(in_row) * w + in_col;
    outc = longint'(out_row) * w + out_col;
    dly = longint'(r) * w + r;
    if (!done && inc < outc + dly + 1) return;
    x = out_col;
    y = out_row;
    if (x < r || y < r || x + r >= w || y + r >= h) begin
      p = fetch(x, y);
      e.red = p[23:16]; e.green = p[15:8]; e.blue = p[7:0];
    end else begin
      sr = 0; sg = 0; sb = 0;
      for (k = 0; k < sz; k++) begin
        for (l = 0; l < sz; l++) begin
          cf = coef_val(k * sz + l);
          p = fetch(x - r + k, y - r + l);
          sr += cf * int'(p[23:16]);
          sg += cf * int'(p[15:8]);
          sb += cf * int'(p[7:0]);
        end
      end
      dv = int'($signed(divisor));
      if (dv != 0) begin
        sr = sr / dv; sg = sg / dv; sb = sb / dv;
      end
      e.red = clamp(sr); e.green = clamp(sg); e.blue = clamp(sb);
    end
    e.frame_end = 1'b0;
    if (out_row + 1 >= h && out_col + 1 >= w) begin
      e.frame_end = 1'b1;
      clear_counters();
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    expected_px.push_back(e);
  endtask

  task automatic report(string what, filtered_t got, filtered_t want);
    errors++;
    $display("ERROR %s: got %h %h %h fe=%b want %h %h %h fe=%b", what,
             got.red, got.green, got.blue, got.frame_end,
             want.red, want.green, want.blue, want.frame_end);
  endtask

  // request driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_if.valid && in_if.ready) begin
      predict_filter(pending_px.pop_front());
      took = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !took) begin
      in_if.valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_if.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      send_gap = $urandom_range(1, 11) - 1;
      in_if.valid <= 1'b0;
    end else if (pending_px.size() > 0) begin
      in_if.valid <= 1'b1;
      in_if.pixel_red <= pending_px[0].red;
      in_if.pixel_green <= pending_px[0].green;
      in_if.pixel_blue <= pending_px[0].blue;
      in_if.pad <= pending_px[0].pad;
    end else begin
      in_if.valid <= 1'b0;
    end
    took = 1'b0;
  end

  // result monitor
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      out_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(1, 11) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    filtered_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.out_red, out_if.out_green, out_if.out_blue, out_if.frame_end};
      if (expected_px.size() == 0) begin
        report("unexpected pixel", got, '0);
      end else begin
        want = expected_px.pop_front();
        if (got.red !== want.red) report("red", got, want);
        if (got.green !== want.green) report("green", got, want);
        if (got.blue !== want.blue) report("blue", got, want);
        if (got.frame_end !== want.frame_end) report("frame_end", got, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 3; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WINDOW_FIVE:  win_five = val[0];
      REG_COEF_A:       coef_a = val;
      REG_COEF_B:       coef_b = val;
      REG_COEF_C:       coef_c = val;
      REG_COEF_D:       coef_d = val[7:0];
      REG_DIVISOR:      divisor = val[15:0];
      REG_FRAME_WIDTH:  frame_w = val[10:0];
      REG_FRAME_HEIGHT: frame_h = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain_all();
    wait (pending_px.size() == 0 && expected_px.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic pixel_t rand_px(bit pad);
    pixel_t p;
    p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
    if ($urandom_range(0, 7) == 0) p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    p.pad = pad;
    return p;
  endfunction

  // queue one whole frame, with stray pads, then just enough drain items
  task automatic add_frame(int pad_pct, int junk_pct);
    int unsigned w, h, r, n, tail, i;
    w = eff_w(frame_w);
    h = eff_h(frame_h);
    r = win_five ? 2 : 1;
    n = w * h;
    for (i = 0; i < n; i++) begin
      while ($urandom_range(0, 99) < pad_pct) pending_px.push_back(rand_px(1'b1));
      pending_px.push_back(rand_px(1'b0));
    end
    tail = r * w + r;
    if (tail > n - 1) tail = n - 1;
    for (i = 0; i < tail; i++)
      pending_px.push_back(rand_px($urandom_range(0, 99) >= junk_pct));
  endtask

  task automatic rand_setup();
    int unsigned k;
    write_reg(REG_WINDOW_FIVE, 64'($urandom_range(0, 1)));
    k = $urandom_range(0, 2);
    write_reg(REG_COEF_A, (k == 0) ? 64'h0303_0303_0303_0303 & {$urandom, $urandom}
                                   : {$urandom, $urandom});
    write_reg(REG_COEF_B, {$urandom, $urandom});
    write_reg(REG_COEF_C, {$urandom, $urandom});
    write_reg(REG_COEF_D, 64'($urandom_range(0, 255)));
    case ($urandom_range(0, 4))
      0: write_reg(REG_DIVISOR, 64'd0);
      1: write_reg(REG_DIVISOR, 64'hFFFF);
      2: write_reg(REG_DIVISOR, 64'($urandom_range(1, 300)));
      3: write_reg(REG_DIVISOR, 64'(-$urandom_range(1, 300)));
      default: write_reg(REG_DIVISOR, 64'($urandom_range(0, 65535)));
    endcase
    write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 5) == 0) ? 64'($urandom_range(13, 40))
                                                           : 64'($urandom_range(1, 12)));
    write_reg(REG_FRAME_HEIGHT, 64'($urandom_range(1, 8)));
  endtask

  initial begin
    int unsigned i;
    win_five = 1'b0; coef_a = '0; coef_b = '0; coef_c = '0; coef_d = '0;
    divisor = '0; frame_w = FRAME_W_RESET; frame_h = FRAME_H_RESET;
    foreach (line_mem[j]) line_mem[j] = '0;
    clear_counters();
    in_if.valid = 1'b0; in_if.pixel_red = '0; in_if.pixel_green = '0;
    in_if.pixel_blue = '0; in_if.pad = 1'b0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni = 1'b1;

    // 5x5, extreme coefficients and divisor -1, saturating sums both ways
    write_reg(REG_WINDOW_FIVE, 64'd1);
    write_reg(REG_COEF_A, 64'h7F80_7F80_7F80_7F80);
    write_reg(REG_COEF_B, 64'h8080_8080_7F7F_7F7F);
    write_reg(REG_COEF_C, 64'h0102_FFFE_7F80_0000);
    write_reg(REG_COEF_D, 64'h80);
    write_reg(REG_DIVISOR, 64'hFFFF);
    write_reg(REG_FRAME_WIDTH, 64'd5);
    write_reg(REG_FRAME_HEIGHT, 64'd5);
    for (i = 0; i < 25; i++)
      pending_px.push_back(i[0] ? pixel_t'({8'hFF, 8'h00, 8'hFF, 1'b0})
                                : pixel_t'({8'h00, 8'hFF, 8'h00, 1'b0}));
    for (i = 0; i < 12; i++) pending_px.push_back(rand_px(i < 6));
    drain_all();

    // width zero and height zero act as one; most negative divisor
    write_reg(REG_WINDOW_FIVE, 64'd0);
    write_reg(REG_DIVISOR, 64'h8000);
    write_reg(REG_FRAME_WIDTH, 64'd0);
    write_reg(REG_FRAME_HEIGHT, 64'd0);
    add_frame(30, 50);
    drain_all();

    // oversized width saturates; long receiver stall fills the block
    write_reg(REG_FRAME_WIDTH, 64'h7FF);
    write_reg(REG_FRAME_HEIGHT, 64'd1);
    hold_off = 400;
    add_frame(0, 0);
    drain_all();

    // geometry shrinks mid-frame: tall frame cut to one line, then to two
    write_reg(REG_FRAME_WIDTH, 64'd1);
    write_reg(REG_FRAME_HEIGHT, 64'hFFFF);
    for (i = 0; i < 3; i++) pending_px.push_back(rand_px(1'b0));
    drain_all();
    write_reg(REG_FRAME_HEIGHT, 64'd1);
    pending_px.push_back(rand_px(1'b1));
    drain_all();
    write_reg(REG_FRAME_HEIGHT, 64'hFFFF);
    for (i = 0; i < 3; i++) pending_px.push_back(rand_px(1'b0));
    drain_all();
    write_reg(REG_FRAME_HEIGHT, 64'd2);
    pending_px.push_back(rand_px(1'b0));
    pending_px.push_back(rand_px(1'b1));
    drain_all();

    // random frames, reconfigured between groups
    i = 0;
    while (i < 1400) begin
      if (i > 1200) calm = 1'b1;
      rand_setup();
      repeat ($urandom_range(1, 3)) begin
        add_frame($urandom_range(0, 15), $urandom_range(0, 40));
        i += eff_w(frame_w) * eff_h(frame_h) * 2;
      end
      drain_all();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/rwc_pkg.sv
hdl/rwc_in_if.sv
hdl/rwc_out_if.sv
hdl/rwc_ram.sv
hdl/rwc_div.sv
hdl/rgb_window_convolution_unit.sv
dv/tb.sv
